/* hdl/m3inv_pkg.sv */
package m3inv_pkg;

    localparam int ELEM_W  = 32;                 // element width
    localparam int FRAC_W  = 16;                 // fraction bits
    localparam int THR_W   = ELEM_W - 1;         // threshold register width
    localparam int N_ELEM  = 9;
    localparam int IN_W    = N_ELEM * ELEM_W;
    localparam int OUT_W   = N_ELEM * ELEM_W;
    localparam int USER_W  = 2;

    localparam int PROD_W  = 2 * ELEM_W;         // element * element
    localparam int COF_W   = 2 * ELEM_W + 1;     // cofactor, signed
    localparam int PP_W    = 2 * ELEM_W + 1;     // det partial product
    localparam int DET_W   = 3 * ELEM_W + 3;     // determinant, signed
    localparam int LIM_W   = THR_W + 1 + 2 * FRAC_W;
    localparam int NUM_SH  = 2 * FRAC_W + 1;     // numerator pre-shift
    localparam int NUM_W   = COF_W + NUM_SH + 1;
    localparam int REM_W   = ((NUM_W > DET_W) ? NUM_W : DET_W) + ELEM_W;
    localparam int Q_W     = ELEM_W;             // quotient bits after range check

    // pipeline: 7 front stages, range check, Q_W divide steps, output stage
    localparam int ST_CHK  = 8;
    localparam int NS      = ST_CHK + Q_W + 1;

    // m_tuser bit positions
    localparam int U_INV   = 0;
    localparam int U_SAT   = 1;

    typedef logic [3:0] idx_t;
    typedef idx_t idx_tab_t [N_ELEM];
    typedef idx_t det_tab_t [3];

    // cofactor k = a[P]*a[Q] - a[R]*a[S], row-major element indexes
    localparam idx_tab_t COF_P = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
    localparam idx_tab_t COF_Q = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
    localparam idx_tab_t COF_R = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
    localparam idx_tab_t COF_S = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

    // first-row expansion uses adjugate entries 11, 21, 31
    localparam det_tab_t DET_IDX = '{4'd0, 4'd3, 4'd6};

endpackage

/* hdl/matrix3x3_inverse.sv */
// matrix3x3_inverse: 3x3 signed Q16.16 inverse by adjugate and determinant.
// Pipeline: 7 arithmetic stages, one range-check stage, 32 restoring-divide
// stages, one output stage. Throughput: one matrix per cycle while m_tready
// is high; set by the fully pipelined divide chain.
// Reset (rst_n low, async): pipeline empties, singular_threshold returns to 1.
module matrix3x3_inverse
(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration: singular_threshold
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [m3inv_pkg::THR_W-1:0]   cfg_data,
    // input matrix
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [m3inv_pkg::IN_W-1:0]    s_tdata,   // a11,a12,a13,a21,..,a33 from bit 0
    // result
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [m3inv_pkg::OUT_W-1:0]   m_tdata,   // inv11,inv12,..,inv33 from bit 0
    output logic [m3inv_pkg::USER_W-1:0]  m_tuser    // bit 0 invertible, bit 1 saturated
);
    import m3inv_pkg::*;

    // ------------------------------------------------------------------
    // Pipeline control. Each stage moves when it is empty or the next one
    // moves, so bubbles collapse and a stalled output does not block the
    // input until every stage holds a request.
    // ------------------------------------------------------------------
    logic          vld_reg [1:NS];
    logic          en      [1:NS+1];
    logic [THR_W-1:0] thr_reg;

    assign en[NS+1] = m_tready;
    for (genvar k = 1; k <= NS; k++) begin : g_en
        assign en[k] = !vld_reg[k] || en[k+1];
    end

    assign s_tready  = en[1];
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[1] <= 1'b0;
        end
        else if (en[1])
        begin
            vld_reg[1] <= s_tvalid;
        end
    end

    for (genvar k = 2; k <= NS; k++) begin : g_vld
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en[k])
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_W'(1);
        end
        else if (cfg_valid)
        begin
            thr_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: the 18 cofactor products, 32x32 each
    // ------------------------------------------------------------------
    logic signed [ELEM_W-1:0] a_in [N_ELEM];
    logic signed [PROD_W-1:0] pq_next [N_ELEM];
    logic signed [PROD_W-1:0] rs_next [N_ELEM];
    logic signed [PROD_W-1:0] pq_reg  [N_ELEM];
    logic signed [PROD_W-1:0] rs_reg  [N_ELEM];
    logic signed [ELEM_W-1:0] a1_s1_reg [3];

    always_comb
    begin
        for (int i = 0; i < N_ELEM; i++)
        begin
            a_in[i] = $signed(s_tdata[i*ELEM_W +: ELEM_W]);
        end
        for (int i = 0; i < N_ELEM; i++)
        begin
            pq_next[i] = a_in[COF_P[i]] * a_in[COF_Q[i]];
            rs_next[i] = a_in[COF_R[i]] * a_in[COF_S[i]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            pq_reg <= pq_next;
            rs_reg <= rs_next;
            for (int k = 0; k < 3; k++)
            begin
                a1_s1_reg[k] <= a_in[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: cofactors (exact, 65 bits)
    // ------------------------------------------------------------------
    logic signed [COF_W-1:0]  cof_next [N_ELEM];
    logic signed [COF_W-1:0]  cof_reg  [N_ELEM];
    logic signed [ELEM_W-1:0] a1_s2_reg [3];

    always_comb
    begin
        for (int i = 0; i < N_ELEM; i++)
        begin
            cof_next[i] = COF_W'(pq_reg[i]) - COF_W'(rs_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            cof_reg   <= cof_next;
            a1_s2_reg <= a1_s1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: det partial products, cofactor split in low/high halves
    // ------------------------------------------------------------------
    logic signed [PP_W-1:0]  pl_next [3];
    logic signed [PP_W-1:0]  ph_next [3];
    logic signed [PP_W-1:0]  pl_reg  [3];
    logic signed [PP_W-1:0]  ph_reg  [3];
    logic signed [COF_W-1:0] cof_s3_reg [N_ELEM];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pl_next[k] = a1_s2_reg[k]
                       * $signed({1'b0, cof_reg[DET_IDX[k]][ELEM_W-1:0]});
            ph_next[k] = a1_s2_reg[k]
                       * $signed(cof_reg[DET_IDX[k]][COF_W-1:ELEM_W]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            pl_reg     <= pl_next;
            ph_reg     <= ph_next;
            cof_s3_reg <= cof_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: recombine halves of each term
    // ------------------------------------------------------------------
    logic signed [DET_W-1:0] term_next [3];
    logic signed [DET_W-1:0] term_reg  [3];
    logic signed [COF_W-1:0] cof_s4_reg [N_ELEM];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            term_next[k] = (DET_W'(ph_reg[k]) <<< ELEM_W) + DET_W'(pl_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            term_reg   <= term_next;
            cof_s4_reg <= cof_s3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: determinant
    // ------------------------------------------------------------------
    logic signed [DET_W-1:0] det_next;
    logic signed [DET_W-1:0] det_reg;
    logic signed [COF_W-1:0] cof_s5_reg [N_ELEM];

    assign det_next = term_reg[0] + term_reg[1] + term_reg[2];

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            det_reg    <= det_next;
            cof_s5_reg <= cof_s4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: magnitudes and signs
    // ------------------------------------------------------------------
    logic [DET_W-1:0] mag_next;
    logic [DET_W-1:0] mag_reg;
    logic             dneg_reg;
    logic [COF_W-1:0] aadj_next [N_ELEM];
    logic [COF_W-1:0] aadj_reg  [N_ELEM];
    logic             aneg_reg  [N_ELEM];

    always_comb
    begin
        mag_next = det_reg[DET_W-1] ? DET_W'(-det_reg) : DET_W'(det_reg);
        for (int i = 0; i < N_ELEM; i++)
        begin
            aadj_next[i] = cof_s5_reg[i][COF_W-1] ? COF_W'(-cof_s5_reg[i])
                                                  : COF_W'(cof_s5_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            mag_reg  <= mag_next;
            dneg_reg <= det_reg[DET_W-1];
            aadj_reg <= aadj_next;
            for (int i = 0; i < N_ELEM; i++)
            begin
                aneg_reg[i] <= cof_s5_reg[i][COF_W-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: singular test, numerators (|adj| << 2F+1) + |det|, 2|det|
    // ------------------------------------------------------------------
    logic [LIM_W-1:0] limit;
    logic             sing_next;
    logic [REM_W-1:0] num_next [N_ELEM];
    logic [REM_W-1:0] num_reg  [N_ELEM];
    logic             neg_reg  [N_ELEM];
    logic [DET_W-1:0] d2_reg;
    logic             sing_reg;

    always_comb
    begin
        limit     = (LIM_W'(thr_reg) + LIM_W'(1)) << (2 * FRAC_W);
        sing_next = mag_reg < DET_W'(limit);
        for (int i = 0; i < N_ELEM; i++)
        begin
            num_next[i] = (REM_W'(aadj_reg[i]) << NUM_SH) + REM_W'(mag_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            num_reg  <= num_next;
            d2_reg   <= DET_W'({mag_reg, 1'b0});
            sing_reg <= sing_next;
            for (int i = 0; i < N_ELEM; i++)
            begin
                neg_reg[i] <= aneg_reg[i] ^ dneg_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: range check (quotient >= 2^Q_W clips), then Q_W restoring
    // divide steps, one quotient bit per stage, MSB first.
    // ------------------------------------------------------------------
    logic [REM_W-1:0] dv_rem_reg  [Q_W+1][N_ELEM];
    logic [Q_W-1:0]   dv_q_reg    [Q_W+1][N_ELEM];
    logic             dv_ovf_reg  [Q_W+1][N_ELEM];
    logic             dv_neg_reg  [Q_W+1][N_ELEM];
    logic [DET_W-1:0] dv_d2_reg   [Q_W+1];
    logic             dv_sing_reg [Q_W+1];

    always_ff @(posedge clk)
    begin
        if (en[ST_CHK])
        begin
            for (int i = 0; i < N_ELEM; i++)
            begin
                dv_rem_reg[0][i] <= num_reg[i];
                dv_q_reg[0][i]   <= '0;
                dv_ovf_reg[0][i] <= num_reg[i] >= (REM_W'(d2_reg) << Q_W);
                dv_neg_reg[0][i] <= neg_reg[i];
            end
            dv_d2_reg[0]   <= d2_reg;
            dv_sing_reg[0] <= sing_reg;
        end
    end

    for (genvar s = 0; s < Q_W; s++) begin : g_div
        localparam int BIT = Q_W - 1 - s;
        logic [REM_W-1:0] trial [N_ELEM];
        logic             take  [N_ELEM];

        always_comb
        begin
            for (int i = 0; i < N_ELEM; i++)
            begin
                trial[i] = REM_W'(dv_d2_reg[s]) << BIT;
                take[i]  = dv_rem_reg[s][i] >= trial[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[ST_CHK+1+s])
            begin
                for (int i = 0; i < N_ELEM; i++)
                begin
                    dv_rem_reg[s+1][i] <= take[i] ? dv_rem_reg[s][i] - trial[i]
                                                  : dv_rem_reg[s][i];
                    dv_q_reg[s+1][i]   <= {dv_q_reg[s][i][Q_W-2:0], take[i]};
                    dv_ovf_reg[s+1][i] <= dv_ovf_reg[s][i];
                    dv_neg_reg[s+1][i] <= dv_neg_reg[s][i];
                end
                dv_d2_reg[s+1]   <= dv_d2_reg[s];
                dv_sing_reg[s+1] <= dv_sing_reg[s];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: clip to Q16.16, apply sign, zero when singular
    // ------------------------------------------------------------------
    logic [ELEM_W-1:0] res_next [N_ELEM];
    logic              clip     [N_ELEM];
    logic              sat_next;
    logic [OUT_W-1:0]  data_next;
    logic [OUT_W-1:0]  data_reg;
    logic [USER_W-1:0] user_reg;

    always_comb
    begin
        sat_next  = 1'b0;
        data_next = '0;
        for (int i = 0; i < N_ELEM; i++)
        begin
            logic [Q_W-1:0] q;
            logic           ng;
            q  = dv_q_reg[Q_W][i];
            ng = dv_neg_reg[Q_W][i];
            // negative side reaches one step further than positive side
            clip[i] = dv_ovf_reg[Q_W][i]
                   || (ng ? (q[Q_W-1] && (q[Q_W-2:0] != '0)) : q[Q_W-1]);
            if (clip[i])
            begin
                res_next[i] = ng ? {1'b1, {(ELEM_W-1){1'b0}}}
                                 : {1'b0, {(ELEM_W-1){1'b1}}};
            end
            else
            begin
                res_next[i] = ng ? ELEM_W'(-q) : ELEM_W'(q);
            end
            if (!dv_sing_reg[Q_W])
            begin
                sat_next = sat_next | clip[i];
                data_next[i*ELEM_W +: ELEM_W] = res_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NS])
        begin
            data_reg        <= data_next;
            user_reg[U_INV] <= !dv_sing_reg[Q_W];
            user_reg[U_SAT] <= sat_next;
        end
    end

    assign m_tvalid = vld_reg[NS];
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // an empty output stage never holds back the input
    a_free_input: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[NS] |-> s_tready)
        else $error("input blocked while output stage empty");

    // singular result carries zero data and no clip flag
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[U_INV]) |-> (m_tdata == '0 && !m_tuser[U_SAT]))
        else $error("singular result not cleared");

    // a stalled first stage keeps its request
    a_stage1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[1] && !en[1]) |=> (vld_reg[1] && $stable(pq_reg[0])))
        else $error("stage 1 request lost under stall");

endmodule
